// ===== rtl/core/mtl_pkg.sv =====
`timescale 1ns / 1ps

package mtl_pkg;

    localparam logic [4:0] KIND_BAD    = 5'd0;
    localparam logic [4:0] KIND_INT    = 5'd1;
    localparam logic [4:0] KIND_FLOAT  = 5'd2;
    localparam logic [4:0] KIND_ID     = 5'd3;
    localparam logic [4:0] KIND_LET    = 5'd4;
    localparam logic [4:0] KIND_IN     = 5'd5;
    localparam logic [4:0] KIND_REC    = 5'd6;
    localparam logic [4:0] KIND_IF     = 5'd7;
    localparam logic [4:0] KIND_THEN   = 5'd8;
    localparam logic [4:0] KIND_ELSE   = 5'd9;
    localparam logic [4:0] KIND_PLUS   = 5'd10;
    localparam logic [4:0] KIND_MINUS  = 5'd11;
    localparam logic [4:0] KIND_TIMES  = 5'd12;
    localparam logic [4:0] KIND_FPLUS  = 5'd13;
    localparam logic [4:0] KIND_FMINUS = 5'd14;
    localparam logic [4:0] KIND_FTIMES = 5'd15;
    localparam logic [4:0] KIND_SEMI2  = 5'd16;
    localparam logic [4:0] KIND_LPAREN = 5'd17;
    localparam logic [4:0] KIND_RPAREN = 5'd18;
    localparam logic [4:0] KIND_EQUAL  = 5'd19;
    localparam logic [4:0] KIND_COMMA  = 5'd20;
    localparam logic [4:0] KIND_QUIT   = 5'd21;

    // Keyword text, first character in the low byte
    localparam logic [63:0] WORD_LET  = 64'h0000_0000_0074_656c;
    localparam logic [63:0] WORD_IN   = 64'h0000_0000_0000_6e69;
    localparam logic [63:0] WORD_REC  = 64'h0000_0000_0063_6572;
    localparam logic [63:0] WORD_IF   = 64'h0000_0000_0000_6669;
    localparam logic [63:0] WORD_THEN = 64'h0000_0000_6e65_6874;
    localparam logic [63:0] WORD_ELSE = 64'h0000_0000_6573_6c65;
    localparam logic [63:0] WORD_QUIT = 64'h0000_0074_6975_7123;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] text;
        logic [3:0]  len;
        logic [26:0] num;
        logic [2:0]  frac;
        logic        err;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok_a;
        token_t     tok_b;
    } front_out_t;

endpackage

// ===== rtl/core/mtl_front.sv =====
`timescale 1ns / 1ps

module mtl_front #(
    parameter int MAX_TEXT = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            char_in,
    output mtl_pkg::front_out_t   fout
);

    typedef enum logic [3:0] {
        S_INIT, S_INT, S_DOT, S_FRAC, S_ID, S_SHARP, S_CMD,
        S_PLUSW, S_MINUSW, S_TIMESW, S_SEMIW, S_CMDSEMIW
    } state_t;

    typedef struct packed {
        state_t      st;
        logic [63:0] text;
        logic [3:0]  cnt;
        logic [26:0] acc;
        logic [2:0]  frac;
        logic        err;
    } lex_t;

    typedef struct packed {
        lex_t             nxt;
        logic             emit;
        mtl_pkg::token_t  tok;
        logic             again;
    } step_t;

    localparam logic [3:0] TextLim = 4'(MAX_TEXT - 1);

    lex_t  lex_reg;
    lex_t  lex_next;
    step_t h1;
    step_t h2;

    function automatic mtl_pkg::token_t make_tok(lex_t s, logic [4:0] k,
                                                 logic [26:0] n, logic [2:0] f);
        mtl_pkg::token_t t;
        t.kind = k;
        t.text = s.text;
        t.len  = s.cnt;
        t.num  = n;
        t.frac = f;
        t.err  = s.err;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic lex_t append(lex_t s, logic [7:0] c);
        lex_t w;
        w = s;
        if (s.cnt < 4'd8)
        begin
            w.text[{s.cnt[2:0], 3'b000} +: 8] = c;
            w.cnt = s.cnt + 4'd1;
        end
        return w;
    endfunction

    function automatic logic [26:0] mul10(logic [26:0] a);
        return (a << 3) + (a << 1);
    endfunction

    function automatic logic [4:0] word_kind(lex_t s);
        logic [4:0] k;
        k = mtl_pkg::KIND_ID;
        if (s.cnt == 4'd3 && s.text == mtl_pkg::WORD_LET)       k = mtl_pkg::KIND_LET;
        else if (s.cnt == 4'd2 && s.text == mtl_pkg::WORD_IN)   k = mtl_pkg::KIND_IN;
        else if (s.cnt == 4'd3 && s.text == mtl_pkg::WORD_REC)  k = mtl_pkg::KIND_REC;
        else if (s.cnt == 4'd2 && s.text == mtl_pkg::WORD_IF)   k = mtl_pkg::KIND_IF;
        else if (s.cnt == 4'd4 && s.text == mtl_pkg::WORD_THEN) k = mtl_pkg::KIND_THEN;
        else if (s.cnt == 4'd4 && s.text == mtl_pkg::WORD_ELSE) k = mtl_pkg::KIND_ELSE;
        return k;
    endfunction

    function automatic step_t handle(lex_t s, logic [7:0] c);
        step_t       r;
        lex_t        w;
        logic        dig;
        logic        alp;
        logic        spc;
        logic        done;
        logic [4:0]  base;
        state_t      st0;
        r    = '0;
        w    = s;
        done = 1'b0;
        base = mtl_pkg::KIND_PLUS;
        dig  = (c >= 8'h30) && (c <= 8'h39);
        alp  = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
        spc  = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
        case (s.st)
            S_INT:
            begin
                if (!dig && c != 8'h2e)
                begin
                    r.emit  = 1'b1;
                    r.tok   = make_tok(s, mtl_pkg::KIND_INT, s.err ? 27'd0 : s.acc, 3'd0);
                    r.again = 1'b1;
                    done    = 1'b1;
                end
            end
            S_FRAC:
            begin
                if (!dig)
                begin
                    r.emit  = 1'b1;
                    r.tok   = make_tok(s, mtl_pkg::KIND_FLOAT, s.err ? 27'd0 : s.acc,
                                       s.err ? 3'd0 : s.frac);
                    r.again = 1'b1;
                    done    = 1'b1;
                end
            end
            S_DOT:
            begin
                if (!dig)
                begin
                    if (s.cnt < TextLim)
                        w = append(s, 8'h30);
                    r.emit  = 1'b1;
                    r.tok   = make_tok(w, mtl_pkg::KIND_FLOAT, s.err ? 27'd0 : mul10(s.acc),
                                       s.err ? 3'd0 : 3'd1);
                    r.again = 1'b1;
                    done    = 1'b1;
                end
            end
            S_ID:
            begin
                if (!alp && !dig)
                begin
                    r.emit  = 1'b1;
                    r.tok   = make_tok(s, word_kind(s), 27'd0, 3'd0);
                    r.again = 1'b1;
                    done    = 1'b1;
                end
            end
            S_CMD:
            begin
                if (!alp && !dig)
                begin
                    done = 1'b1;
                    if (c == 8'h3b)
                        w.st = S_CMDSEMIW;
                    else
                    begin
                        w.err  = 1'b1;
                        r.emit = 1'b1;
                        r.tok  = make_tok(w, mtl_pkg::KIND_BAD, 27'd0, 3'd0);
                    end
                end
            end
            S_PLUSW, S_MINUSW, S_TIMESW:
            begin
                if (s.st == S_MINUSW)      base = mtl_pkg::KIND_MINUS;
                else if (s.st == S_TIMESW) base = mtl_pkg::KIND_TIMES;
                r.emit = 1'b1;
                done   = 1'b1;
                if (c == 8'h2e)
                    r.tok = make_tok(s, base + 5'd3, 27'd0, 3'd0);
                else
                begin
                    r.tok   = make_tok(s, base, 27'd0, 3'd0);
                    r.again = 1'b1;
                end
            end
            S_SEMIW:
            begin
                done   = 1'b1;
                r.emit = 1'b1;
                if (c == 8'h3b)
                    r.tok = make_tok(s, mtl_pkg::KIND_SEMI2, 27'd0, 3'd0);
                else
                begin
                    w.err = 1'b1;
                    r.tok = make_tok(w, mtl_pkg::KIND_BAD, 27'd0, 3'd0);
                end
            end
            S_CMDSEMIW:
            begin
                done   = 1'b1;
                r.emit = 1'b1;
                if (c == 8'h3b && s.cnt == 4'd5 && s.text == mtl_pkg::WORD_QUIT)
                    r.tok = make_tok(s, mtl_pkg::KIND_QUIT, 27'd0, 3'd0);
                else
                begin
                    w.err = 1'b1;
                    r.tok = make_tok(w, mtl_pkg::KIND_BAD, 27'd0, 3'd0);
                end
            end
            default:
            begin
                w = s;
            end
        endcase

        if (!done && !spc)
        begin
            if (w.cnt >= TextLim)
            begin
                r.emit = 1'b1;
                r.tok  = make_tok(w, mtl_pkg::KIND_BAD, 27'd0, 3'd0);
            end
            else
            begin
                st0 = w.st;
                w   = append(w, c);
                case (c)
                    8'h2b: w.st = S_PLUSW;
                    8'h2d: w.st = S_MINUSW;
                    8'h2a: w.st = S_TIMESW;
                    8'h3b: w.st = S_SEMIW;
                    8'h28:
                    begin
                        r.emit = 1'b1;
                        r.tok  = make_tok(w, mtl_pkg::KIND_LPAREN, 27'd0, 3'd0);
                    end
                    8'h29:
                    begin
                        r.emit = 1'b1;
                        r.tok  = make_tok(w, mtl_pkg::KIND_RPAREN, 27'd0, 3'd0);
                    end
                    8'h3d:
                    begin
                        r.emit = 1'b1;
                        r.tok  = make_tok(w, mtl_pkg::KIND_EQUAL, 27'd0, 3'd0);
                    end
                    8'h2c:
                    begin
                        r.emit = 1'b1;
                        r.tok  = make_tok(w, mtl_pkg::KIND_COMMA, 27'd0, 3'd0);
                    end
                    default:
                    begin
                        if (dig)
                        begin
                            if (st0 == S_INIT)     w.st = S_INT;
                            else if (st0 == S_DOT) w.st = S_FRAC;
                            if (w.st == S_INT || w.st == S_FRAC)
                                w.acc = mul10(w.acc) + 27'(c[3:0]);
                            if (w.st == S_FRAC)
                                w.frac = w.frac + 3'd1;
                        end
                        else if (c == 8'h2e)
                        begin
                            if (st0 == S_INT) w.st = S_DOT;
                            else              w.err = 1'b1;
                        end
                        else if (alp)
                        begin
                            if (st0 == S_SHARP)     w.st = S_CMD;
                            else if (st0 == S_INIT) w.st = S_ID;
                        end
                        else if (c == 8'h23)
                        begin
                            if (st0 == S_INIT) w.st = S_SHARP;
                            else               w.err = 1'b1;
                        end
                        else
                            w.err = 1'b1;
                    end
                endcase
            end
        end

        // Emitting a token clears the collection state
        if (r.emit)
            w = '0;
        r.nxt = w;
        return r;
    endfunction

    always_comb
    begin
        h1 = handle(lex_reg, char_in);
        h2 = h1.again ? handle('0, char_in) : '0;
        lex_next = h1.again ? h2.nxt : h1.nxt;
        fout.count = 2'(h1.emit) + 2'(h2.emit);
        fout.tok_a = h1.tok;
        fout.tok_b = h2.tok;
        if (h2.emit)
            fout.tok_b.last = 1'b1;
        else
            fout.tok_a.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lex_reg <= '0;
        else if (step)
            lex_reg <= lex_next;
    end

endmodule

// ===== rtl/core/mtl_queue.sv =====
`timescale 1ns / 1ps

module mtl_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   push_count,
    input  mtl_pkg::token_t              push_a,
    input  mtl_pkg::token_t              push_b,
    input  logic                         pop,
    output mtl_pkg::token_t              head,
    output logic [mtl_pkg::QPTR_W:0]     level
);

    mtl_pkg::token_t              entry_reg [mtl_pkg::QUEUE_DEPTH];
    logic [mtl_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [mtl_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [mtl_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [mtl_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [mtl_pkg::QPTR_W:0]     level_reg;
    logic [mtl_pkg::QPTR_W:0]     level_next;
    logic [mtl_pkg::QPTR_W-1:0]   wr_ptr_b;

    assign wr_ptr_b    = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + mtl_pkg::QPTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + mtl_pkg::QPTR_W'(pop);
    assign level_next  = level_reg + (mtl_pkg::QPTR_W + 1)'(push_count)
                         - (mtl_pkg::QPTR_W + 1)'(pop);
    assign head        = entry_reg[rd_ptr_reg];
    assign level       = level_reg;

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push_a;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_b] <= push_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== rtl/core/ml_token_lexer_core.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_stall    char_in
// output   out        out_valid / out_stall  token_kind, token_text, text_length,
//                                            number_digits, fraction_digits,
//                                            error_seen, last_of_run
//
// One character per cycle enters the lexer unless input stalls; it yields
// zero, one or two tokens in that same cycle, written into a four-entry
// token queue. The queue drains one token per cycle unless output stalls,
// so a character that yields two tokens uses more output bandwidth than
// input bandwidth; input stalls when fewer than two queue slots are free.
// Reset clears the lexer state and empties the queue; no clearing pass.
// Output stall only backs up the queue; the lexer keeps going until input stalls.

module ml_token_lexer_core #(
    parameter int MAX_TEXT = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [63:0] token_text,
    output logic [3:0]  text_length,
    output logic [26:0] number_digits,
    output logic [2:0]  fraction_digits,
    output logic        error_seen,
    output logic        last_of_run
);

    mtl_pkg::front_out_t          fout;
    mtl_pkg::token_t              head;
    logic [mtl_pkg::QPTR_W:0]     level;
    logic                         in_take;
    logic                         out_take;
    logic [1:0]                   push_count;

    // Hold input unless two free slots remain for a worst-case character
    assign in_stall   = level > (mtl_pkg::QPTR_W + 1)'(mtl_pkg::QUEUE_DEPTH - 2);
    assign in_take    = in_valid && !in_stall;
    assign out_valid  = level != '0;
    assign out_take   = out_valid && !out_stall;
    // Drop the front's results unless the transaction actually happens
    assign push_count = in_take ? fout.count : 2'd0;

    mtl_front #(
        .MAX_TEXT (MAX_TEXT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_take),
        .char_in (char_in),
        .fout    (fout)
    );

    mtl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_a     (fout.tok_a),
        .push_b     (fout.tok_b),
        .pop        (out_take),
        .head       (head),
        .level      (level)
    );

    assign token_kind      = head.kind;
    assign token_text      = head.text;
    assign text_length     = head.len;
    assign number_digits   = head.num;
    assign fraction_digits = head.frac;
    assign error_seen      = head.err;
    assign last_of_run     = head.last;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= (mtl_pkg::QPTR_W + 1)'(mtl_pkg::QUEUE_DEPTH))
        else $error("token queue overflow");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= mtl_pkg::KIND_QUIT)
        else $error("token kind out of range");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> text_length <= 4'd8)
        else $error("token text length out of range");

    a_two_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && fout.count == 2'd2) |=> out_valid)
        else $error("two tokens pushed but queue empty");

endmodule

// ===== test/ml_token_lexer_checker.sv =====
`timescale 1ns / 1ps

module ml_token_lexer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [4:0]  token_kind,
    input  logic [63:0] token_text,
    input  logic [3:0]  text_length,
    input  logic [26:0] number_digits,
    input  logic [2:0]  fraction_digits,
    input  logic        error_seen,
    input  logic        last_of_run,
    output int          error_count,
    output int          pending_tokens,
    output int          token_total
);

    localparam int MAX_TEXT = 9;

    typedef enum logic [3:0] {
        LX_INIT, LX_INT, LX_DOT, LX_FRAC, LX_ID, LX_SHARP, LX_CMD,
        LX_PLUSW, LX_MINUSW, LX_TIMESW, LX_SEMIW, LX_CMDSEMIW
    } lex_state_e;

    lex_state_e  st_q;
    logic [63:0] buf_q;
    logic [3:0]  cnt_q;
    logic [26:0] acc_q;
    logic [2:0]  frac_q;
    logic        err_q;

    mtl_pkg::token_t expected_tokens[$];
    mtl_pkg::token_t fresh[$];

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit holds(logic [63:0] w, int n);
        return cnt_q == n && buf_q == w;
    endfunction

    function automatic void add_char(logic [7:0] c);
        if (cnt_q < 8)
        begin
            buf_q[8*cnt_q +: 8] = c;
            cnt_q++;
        end
    endfunction

    function automatic void push_token(logic [4:0] kind, logic [26:0] num, logic [2:0] frac);
        mtl_pkg::token_t t;
        t.kind = kind; t.text = buf_q; t.len = cnt_q;
        t.num = num; t.frac = frac; t.err = err_q; t.last = 1'b0;
        fresh.push_back(t);
        st_q = LX_INIT; buf_q = '0; cnt_q = '0; acc_q = '0; frac_q = '0; err_q = 1'b0;
    endfunction

    function automatic void push_number(logic [4:0] kind, logic [26:0] num,
                                        logic [2:0] frac);
        if (err_q) push_token(kind, '0, '0);
        else push_token(kind, num, frac);
    endfunction

    // Advance the lexer by one character; return 1 when it must be rescanned.
    function automatic bit lex_char(logic [7:0] c);
        lex_state_e st;
        logic [4:0] kind;
        st = st_q;
        case (st)
            LX_INT:
                if (!is_digit(c) && c != ".")
                begin
                    push_number(mtl_pkg::KIND_INT, acc_q, 3'd0);
                    return 1;
                end
            LX_FRAC:
                if (!is_digit(c))
                begin
                    push_number(mtl_pkg::KIND_FLOAT, acc_q, frac_q);
                    return 1;
                end
            LX_DOT:
                if (!is_digit(c))
                begin
                    if (cnt_q < MAX_TEXT - 1) add_char("0");
                    push_number(mtl_pkg::KIND_FLOAT, 27'(acc_q * 27'd10), 3'd1);
                    return 1;
                end
            LX_ID:
                if (!is_alpha(c) && !is_digit(c))
                begin
                    kind = mtl_pkg::KIND_ID;
                    if (holds(mtl_pkg::WORD_LET, 3)) kind = mtl_pkg::KIND_LET;
                    else if (holds(mtl_pkg::WORD_IN, 2)) kind = mtl_pkg::KIND_IN;
                    else if (holds(mtl_pkg::WORD_REC, 3)) kind = mtl_pkg::KIND_REC;
                    else if (holds(mtl_pkg::WORD_IF, 2)) kind = mtl_pkg::KIND_IF;
                    else if (holds(mtl_pkg::WORD_THEN, 4)) kind = mtl_pkg::KIND_THEN;
                    else if (holds(mtl_pkg::WORD_ELSE, 4)) kind = mtl_pkg::KIND_ELSE;
                    push_token(kind, 0, 0);
                    return 1;
                end
            LX_CMD:
                if (!is_alpha(c) && !is_digit(c))
                begin
                    if (c == ";")
                    begin
                        st_q = LX_CMDSEMIW;
                        return 0;
                    end
                    err_q = 1'b1;
                    push_token(mtl_pkg::KIND_BAD, 0, 0);
                    return 0;
                end
            LX_PLUSW, LX_MINUSW, LX_TIMESW:
            begin
                kind = mtl_pkg::KIND_PLUS;
                if (st == LX_MINUSW) kind = mtl_pkg::KIND_MINUS;
                else if (st == LX_TIMESW) kind = mtl_pkg::KIND_TIMES;
                if (c == ".")
                begin
                    push_token(kind + 5'd3, 0, 0);
                    return 0;
                end
                push_token(kind, 0, 0);
                return 1;
            end
            LX_SEMIW:
            begin
                if (c == ";") push_token(mtl_pkg::KIND_SEMI2, 0, 0);
                else
                begin
                    err_q = 1'b1;
                    push_token(mtl_pkg::KIND_BAD, 0, 0);
                end
                return 0;
            end
            LX_CMDSEMIW:
            begin
                if (c == ";" && holds(mtl_pkg::WORD_QUIT, 5))
                    push_token(mtl_pkg::KIND_QUIT, 0, 0);
                else
                begin
                    err_q = 1'b1;
                    push_token(mtl_pkg::KIND_BAD, 0, 0);
                end
                return 0;
            end
            default: ;
        endcase

        if (c == " " || (c >= 9 && c <= 13)) return 0;
        if (cnt_q >= MAX_TEXT - 1)
        begin
            push_token(mtl_pkg::KIND_BAD, 0, 0);
            return 0;
        end
        add_char(c);

        if (c == "+") st_q = LX_PLUSW;
        else if (c == "-") st_q = LX_MINUSW;
        else if (c == "*") st_q = LX_TIMESW;
        else if (c == ";") st_q = LX_SEMIW;
        else if (c == "(") push_token(mtl_pkg::KIND_LPAREN, 0, 0);
        else if (c == ")") push_token(mtl_pkg::KIND_RPAREN, 0, 0);
        else if (c == "=") push_token(mtl_pkg::KIND_EQUAL, 0, 0);
        else if (c == ",") push_token(mtl_pkg::KIND_COMMA, 0, 0);
        else if (is_digit(c))
        begin
            if (st == LX_INIT) st_q = LX_INT;
            else if (st == LX_DOT) st_q = LX_FRAC;
            if (st_q == LX_INT || st_q == LX_FRAC)
            begin
                acc_q = 27'(acc_q * 27'd10 + 27'(c - 8'h30));
                if (st_q == LX_FRAC) frac_q = frac_q + 3'd1;
            end
        end
        else if (c == ".")
        begin
            if (st == LX_INT) st_q = LX_DOT;
            else err_q = 1'b1;
        end
        else if (is_alpha(c))
        begin
            if (st == LX_SHARP) st_q = LX_CMD;
            else if (st == LX_INIT) st_q = LX_ID;
        end
        else if (c == "#")
        begin
            if (st == LX_INIT) st_q = LX_SHARP;
            else err_q = 1'b1;
        end
        else err_q = 1'b1;
        return 0;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH token %0d %s: got %0h, expected %0h", token_total, what, got, want);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mtl_pkg::token_t w;
        if (!rst_n)
        begin
            st_q <= LX_INIT;
            buf_q <= '0; cnt_q <= '0; acc_q <= '0; frac_q <= '0; err_q <= 1'b0;
            expected_tokens.delete();
            error_count <= 0;
            token_total <= 0;
            pending_tokens <= 0;
        end
        else
        begin
            // Check output before queuing this cycle's predictions.
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                    report("unexpected kind", token_kind, '0);
                else
                begin
                    w = expected_tokens.pop_front();
                    if (token_kind !== w.kind) report("kind", token_kind, w.kind);
                    if (token_text !== w.text) report("text", token_text, w.text);
                    if (text_length !== w.len) report("length", text_length, w.len);
                    if (number_digits !== w.num) report("digits", number_digits, w.num);
                    if (fraction_digits !== w.frac)
                        report("fraction", fraction_digits, w.frac);
                    if (error_seen !== w.err) report("error", error_seen, w.err);
                    if (last_of_run !== w.last) report("last", last_of_run, w.last);
                end
                token_total++;
            end
            if (in_valid && !in_stall)
            begin
                fresh.delete();
                if (lex_char(char_in)) void'(lex_char(char_in));
                if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
                foreach (fresh[i]) expected_tokens.push_back(fresh[i]);
            end
            pending_tokens <= expected_tokens.size();
        end
    end

endmodule

// ===== test/ml_token_lexer_core_tb.sv =====
`timescale 1ns / 1ps

module ml_token_lexer_core_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_in;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  token_kind;
    logic [63:0] token_text;
    logic [3:0]  text_length;
    logic [26:0] number_digits;
    logic [2:0]  fraction_digits;
    logic        error_seen;
    logic        last_of_run;

    int error_count;
    int pending_tokens;
    int token_total;
    int char_total;
    int cycle_count;
    bit calm_phase;

    // Text fragments that steer the lexer through its deeper states
    string phrases[] = '{
        "let", "in", "rec", "if", "then", "else", "#quit;;", "x1", "foo",
        "123", "4.5", "12.", "0.1234567", "99999999", "+", "-.", "*.", ";;",
        "(", ")", "=", ",", "#ab;x", "#q1;;", ";a", "1.2.3", "abcdefghij",
        "#quit;x", "a#b", "@", "7.", " ", "\n", "\t", "+1", "*2", "12345678."
    };

    ml_token_lexer_core uut (.*);

    ml_token_lexer_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Hold the receiver off now and then; no stall during the calm phase.
    always @(negedge clk)
    begin
        out_stall <= !calm_phase && ($urandom_range(0, 99) < 10);
    end

    // Abort on a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 200000)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive one transaction: hold char until the lexer takes it.
    task automatic send_char(logic [7:0] c);
        while (!calm_phase && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        char_total++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_char(s[i]);
    endtask

    initial
    begin
        int pick;
        int hold;
        in_valid = 1'b0;
        char_in = '0;
        out_stall = 1'b0;
        calm_phase = 1'b0;
        cycle_count = 0;
        char_total = 0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, every operator and the awkward endings.
        send_char(8'h00);
        send_char(8'hFF);
        send_text(" let in rec if then else ");
        send_text("+ +. - -. * *. ;; ; x ( ) = , #quit;; #quit;x 12. 3.25 ");
        send_text("12345678. 1.2.3 abcdefghij #ab12 x");

        for (int n = 0; char_total < 945; n++)
        begin
            calm_phase = (n >= 100 && n < 170);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_text(phrases[$urandom_range(0, phrases.size() - 1)]);
            else if (pick < 85)
                send_char(8'($urandom_range(0, 255)));
            else
                send_char(8'($urandom_range(32, 126)));
        end
        calm_phase = 1'b0;
        // Flush any token still being collected, unless only a # has been read so far.
        send_char(" ");
        in_valid <= 1'b0;

        while (pending_tokens != 0) @(posedge clk);
        hold = 0;
        while (hold < 20)
        begin
            @(posedge clk);
            hold++;
        end

        $display("Fed %0d characters, checked %0d tokens over %0d cycles",
                 char_total, token_total, cycle_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
